>>> sv/mcr_pkg.sv
`default_nettype none

package mcr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;

    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN_Q8   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_P_GAIN         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_I_GAIN         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_D_GAIN         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_LIMIT     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE      = 3'd7;

    localparam logic [2:0] MODE_OPEN    = 3'd0;
    localparam logic [2:0] MODE_BANG    = 3'd1;
    localparam logic [2:0] MODE_INC     = 3'd2;
    localparam logic [2:0] MODE_PROP    = 3'd3;
    localparam logic [2:0] MODE_PID     = 3'd4;
    localparam logic [2:0] MODE_PID_ALT = 3'd5;

    localparam logic [10:0] MEAS_MAX = 11'd2047;

    // Multiply-accumulate: 24-bit multipliers taken as six radix-16 digits
    localparam int MAC_DIGITS = 6;
    localparam int MAC_CNT_W  = 3;

    typedef struct packed {
        logic               control_enable;
        logic [2:0]         loop_mode;
        logic signed [15:0] prop_gain_q8;
        logic signed [20:0] p_gain;
        logic signed [20:0] i_gain;
        logic signed [20:0] d_gain;
        logic [14:0]        duty_limit;
        logic [7:0]         step_size;
    } cfg_t;

    typedef struct packed {
        logic signed [16:0] a0;
        logic signed [16:0] a1;
        logic signed [16:0] a2;
        logic [23:0]        g0;
        logic [23:0]        g1;
        logic [23:0]        g2;
    } mac_req_t;

    typedef struct packed {
        logic               done;
        logic               sticky;
        logic signed [33:0] prod;
    } mac_rsp_t;

endpackage

`default_nettype wire

>>> sv/multimode_current_regulator.sv
`default_nettype none

// Channel   Direction  Handshake             Beat
// in        sink       in_valid / in_ready   adc_sample, setpoint_ma
// out       source     out_valid / out_ready duty_value, measured_ma
// cfg       sink       cfg_write             cfg_index, cfg_data
//
// One item at a time: a new in beat is accepted only in the idle state, after
// the last item has left the finish state. Each multiply is six radix-16 digit
// steps of the shared serial MAC unit: one pass scales the sample and, in the
// proportional and PID modes, a second forms the control term. Reset (async,
// active low) sets state, duty, integ, prev and out_valid to their defaults.
// A beat waiting on out does not block the next in beat; the next result
// holds in the finish state until the output register frees up.
module multimode_current_regulator #(
    parameter int FULL_SCALE_MA = 1500
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [15:0]                        adc_sample,
    input  wire logic [10:0]                        setpoint_ma,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [14:0]                             duty_value,
    output logic [10:0]                             measured_ma,
    input  wire logic                               cfg_write,
    input  wire logic [mcr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mcr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mcr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_PLAN,
        S_MUL,
        S_FINISH
    } state_t;

    cfg_t       cfg_q;
    mac_req_t   mac_req;
    mac_rsp_t   mac_rsp;
    logic       mac_start;

    state_t             state_reg, state_next;
    logic [10:0]        setp_reg, setp_next;
    logic [10:0]        meas_reg, meas_next;
    logic [14:0]        duty_reg, duty_next;
    logic signed [15:0] integ_reg, integ_next;
    logic [10:0]        prev_reg, prev_next;
    logic signed [23:0] dsum_reg, dsum_next;
    logic               out_valid_reg, out_valid_next;
    logic [14:0]        duty_out_reg, duty_out_next;
    logic [10:0]        meas_out_reg, meas_out_next;

    logic signed [11:0] err;
    logic signed [12:0] ndm;
    logic signed [16:0] isum;
    logic signed [16:0] lim17;
    logic signed [15:0] iclamp;
    logic signed [23:0] duty_ext;
    logic signed [23:0] lim_ext;
    logic signed [23:0] prod_lo;
    logic signed [23:0] prop_term;
    logic [10:0]        scaled_sat;
    logic [14:0]        dclamp;

    mcr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg_q)
    );

    mcr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .req   (mac_req),
        .rsp   (mac_rsp)
    );

    assign err      = 12'(setp_reg) - 12'(meas_reg);
    assign ndm      = 13'(prev_reg) - 13'(meas_reg);
    assign isum     = 17'(integ_reg) + 17'(err);
    assign lim17    = {2'b00, cfg_q.duty_limit};
    assign duty_ext = {9'd0, duty_reg};
    assign lim_ext  = {9'd0, cfg_q.duty_limit};
    assign prod_lo  = mac_rsp.prod[23:0];

    // proportional quotient rounds toward zero
    assign prop_term = prod_lo + {23'd0, prod_lo[23] && mac_rsp.sticky};

    assign scaled_sat = (|mac_rsp.prod[33:11]) ? MEAS_MAX : mac_rsp.prod[10:0];

    always_comb
    begin
        if (isum > lim17)
        begin
            iclamp = 16'(lim17);
        end
        else if (isum < -lim17)
        begin
            iclamp = 16'(-lim17);
        end
        else
        begin
            iclamp = isum[15:0];
        end
    end

    always_comb
    begin
        if (dsum_reg[23])
        begin
            dclamp = 15'd0;
        end
        else if (dsum_reg > lim_ext)
        begin
            dclamp = cfg_q.duty_limit;
        end
        else
        begin
            dclamp = dsum_reg[14:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        setp_next      = setp_reg;
        meas_next      = meas_reg;
        duty_next      = duty_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        dsum_next      = dsum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        duty_out_next  = duty_out_reg;
        meas_out_next  = meas_out_reg;
        mac_start      = 1'b0;
        mac_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                mac_req.a0 = 17'(FULL_SCALE_MA);
                mac_req.g0 = {8'd0, adc_sample};
                if (in_valid)
                begin
                    mac_start  = 1'b1;
                    setp_next  = setpoint_ma;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (mac_rsp.done)
                begin
                    meas_next  = scaled_sat;
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                state_next = S_FINISH;
                dsum_next  = duty_ext;
                if (cfg_q.control_enable)
                begin
                    case (cfg_q.loop_mode)
                        MODE_OPEN:
                        begin
                            dsum_next = duty_ext;
                        end
                        MODE_BANG:
                        begin
                            dsum_next = (meas_reg < setp_reg) ? lim_ext : 24'sd0;
                        end
                        MODE_INC:
                        begin
                            if (meas_reg < setp_reg)
                            begin
                                dsum_next = duty_ext + {16'd0, cfg_q.step_size};
                            end
                            else
                            begin
                                dsum_next = duty_ext - {16'd0, cfg_q.step_size};
                            end
                        end
                        MODE_PROP:
                        begin
                            mac_start  = 1'b1;
                            mac_req.a0 = 17'(err);
                            mac_req.g0 = {cfg_q.prop_gain_q8, 8'd0};
                            state_next = S_MUL;
                        end
                        MODE_PID, MODE_PID_ALT:
                        begin
                            mac_start  = 1'b1;
                            mac_req.a0 = 17'(err);
                            mac_req.g0 = 24'(cfg_q.p_gain);
                            mac_req.a1 = 17'(iclamp);
                            mac_req.g1 = 24'(cfg_q.i_gain);
                            mac_req.a2 = 17'(ndm);
                            mac_req.g2 = 24'(cfg_q.d_gain);
                            integ_next = iclamp;
                            prev_next  = meas_reg;
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            dsum_next = duty_ext;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                if (mac_rsp.done)
                begin
                    if (cfg_q.loop_mode == MODE_PROP)
                    begin
                        dsum_next = duty_ext + prop_term;
                    end
                    else
                    begin
                        dsum_next = duty_ext + prod_lo;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    duty_next      = cfg_q.control_enable ? dclamp : duty_reg;
                    out_valid_next = 1'b1;
                    duty_out_next  = duty_next;
                    meas_out_next  = meas_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            duty_reg      <= 15'd5;
            integ_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            duty_reg      <= duty_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        setp_reg     <= setp_next;
        meas_reg     <= meas_next;
        dsum_reg     <= dsum_next;
        duty_out_reg <= duty_out_next;
        meas_out_reg <= meas_out_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign duty_value  = duty_out_reg;
    assign measured_ma = meas_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        mac_rsp.done |-> (state_reg == S_SCALE || state_reg == S_MUL))
        else $error("MAC finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result raised without a finished item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !cfg_q.control_enable && (!out_valid_reg || out_ready))
        |=> duty_reg == $past(duty_reg))
        else $error("duty changed while control disabled");

endmodule

`default_nettype wire

>>> sv/mcr_cfg.sv
`default_nettype none

module mcr_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [mcr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mcr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output mcr_pkg::cfg_t                           cfg
);
    import mcr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_enable <= 1'b1;
            cfg_reg.loop_mode      <= MODE_PID_ALT;
            cfg_reg.prop_gain_q8   <= 16'sd64;
            cfg_reg.p_gain         <= 21'sd65536;
            cfg_reg.i_gain         <= 21'sd0;
            cfg_reg.d_gain         <= 21'sd0;
            cfg_reg.duty_limit     <= 15'd200;
            cfg_reg.step_size      <= 8'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CONTROL_ENABLE: cfg_reg.control_enable <= cfg_data[0];
                REG_LOOP_MODE:      cfg_reg.loop_mode      <= cfg_data[2:0];
                REG_PROP_GAIN_Q8:   cfg_reg.prop_gain_q8   <= cfg_data[15:0];
                REG_P_GAIN:         cfg_reg.p_gain         <= cfg_data[20:0];
                REG_I_GAIN:         cfg_reg.i_gain         <= cfg_data[20:0];
                REG_D_GAIN:         cfg_reg.d_gain         <= cfg_data[20:0];
                REG_DUTY_LIMIT:     cfg_reg.duty_limit     <= cfg_data[14:0];
                REG_STEP_SIZE:      cfg_reg.step_size      <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/mcr_mac.sv
`default_nettype none

// Digit-serial sum of three products a*g, multiplier digits LSB first.
// Result is floor(sum / 2^16); sticky flags nonzero bits below bit 16.
module mcr_mac (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire mcr_pkg::mac_req_t  req,
    output mcr_pkg::mac_rsp_t       rsp
);
    import mcr_pkg::*;

    logic signed [16:0]     a0_reg, a1_reg, a2_reg;
    logic [23:0]            g0_reg, g1_reg, g2_reg;
    logic signed [25:0]     h_reg;
    logic [7:0]             low_reg;
    logic                   sticky_reg;
    logic [MAC_CNT_W-1:0]   cnt_reg;
    logic                   run_reg;
    logic                   done_reg;

    logic                   last;
    logic signed [4:0]      dig0, dig1, dig2;
    logic signed [21:0]     p0, p1, p2;
    logic signed [25:0]     t;

    assign last = (cnt_reg == MAC_CNT_W'(MAC_DIGITS - 1));

    // top digit carries the sign of the multiplier
    assign dig0 = last ? {g0_reg[3], g0_reg[3:0]} : {1'b0, g0_reg[3:0]};
    assign dig1 = last ? {g1_reg[3], g1_reg[3:0]} : {1'b0, g1_reg[3:0]};
    assign dig2 = last ? {g2_reg[3], g2_reg[3:0]} : {1'b0, g2_reg[3:0]};

    assign p0 = a0_reg * dig0;
    assign p1 = a1_reg * dig1;
    assign p2 = a2_reg * dig2;

    assign t = h_reg + 26'(p0) + 26'(p1) + 26'(p2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && last && !start;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a0_reg     <= req.a0;
            a1_reg     <= req.a1;
            a2_reg     <= req.a2;
            g0_reg     <= req.g0;
            g1_reg     <= req.g1;
            g2_reg     <= req.g2;
            h_reg      <= '0;
            sticky_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            h_reg   <= t >>> 4;
            low_reg <= {t[3:0], low_reg[7:4]};
            if (cnt_reg < MAC_CNT_W'(MAC_DIGITS - 2) && t[3:0] != 4'd0)
            begin
                sticky_reg <= 1'b1;
            end
            g0_reg <= g0_reg >> 4;
            g1_reg <= g1_reg >> 4;
            g2_reg <= g2_reg >> 4;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.sticky = sticky_reg;
    assign rsp.prod   = {h_reg, low_reg};

endmodule

`default_nettype wire
